// ===== rtl/interval_range_map_unit_assert.svh =====
// Assertion macros used by the checker file irm_chk.sv.
`ifndef INTERVAL_RANGE_MAP_UNIT_ASSERT_SVH
`define INTERVAL_RANGE_MAP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRM_ASSERT_IMPLY(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IRM_ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/irm_pkg.sv =====
`default_nettype none
package irm_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 8;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ASSIGN = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] range_begin;
    logic [KEY_W-1:0] range_end;
    logic [VAL_W-1:0] new_value;
    logic [KEY_W-1:0] lookup_key;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    status_t          status;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } entry_t;

  // HOLD keeps the entry, SHL takes the right neighbor, SHR the left one, WRITE the given data.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHL,
    OP_SHR,
    OP_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   data;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/irm_cell.sv =====
`default_nettype none
module irm_cell import irm_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  cell_ctl_t        ctl,
  input  entry_t           left_ent,
  input  entry_t           right_ent,
  input  wire [KEY_W-1:0]  cmp_b,
  input  wire [KEY_W-1:0]  cmp_x,
  input  wire              valid,
  input  wire              le_next,
  input  wire              lt_next,
  output entry_t           ent,
  output logic             le,
  output logic             lt,
  output logic             hit_le,
  output logic             hit_lt
);

  entry_t ent_r, ent_nxt;

  always_comb begin
    unique case (ctl.op)
      OP_HOLD:  ent_nxt = ent_r;
      OP_SHL:   ent_nxt = right_ent;
      OP_SHR:   ent_nxt = left_ent;
      OP_WRITE: ent_nxt = ctl.data;
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  // The table is sorted, so the last cell of each run is found from its neighbor.
  assign le     = valid && (ent_r.key <= cmp_x);
  assign lt     = valid && (ent_r.key < cmp_b);
  assign hit_le = le && !le_next;
  assign hit_lt = lt && !lt_next;
  assign ent    = ent_r;

endmodule
`default_nettype wire

// ===== rtl/interval_range_map_unit.sv =====
// Channel | Ports                      | Transfer
// input   | start, busy, in_req        | start high while busy low
// result  | out_strobe, out_res        | out_strobe high for one cycle
// config  | cfg_we, cfg_wdata          | cfg_we high while busy low
//
// A lookup, an empty range and a rejected assign are decided in S_EVAL, and the
// result register is loaded as the unit goes back to S_IDLE. An assign that
// changes the table goes from S_EVAL to S_SHIFT, where the cell row moves the
// upper part neighbor to neighbor, a position at a time, before the breakpoints.
// Reset is synchronous and active low; it leaves one breakpoint at key 0 with
// value 0. The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
module interval_range_map_unit import irm_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  in_t              in_req,
  output logic             out_strobe,
  output out_t             out_res,
  input  wire              cfg_we,
  input  wire [VAL_W-1:0]  cfg_wdata
);

  // Count width covers sums up to twice the depth plus two.
  localparam int CW = $clog2(2 * MAX_ENTRIES + 3);

  state_t           state_r, state_nxt;
  in_t              req_r, req_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    p_r, p_nxt;
  logic [CW-1:0]    s_r, s_nxt;
  logic [CW-1:0]    t_r, t_nxt;
  logic [CW-1:0]    ncnt_r, ncnt_nxt;
  logic             kb_r, kb_nxt;
  logic             ke_r, ke_nxt;
  logic [VAL_W-1:0] endv_r, endv_nxt;
  logic             strobe_r, strobe_nxt;
  out_t             res_r, res_nxt;

  entry_t    ent    [MAX_ENTRIES];
  cell_ctl_t ctl    [MAX_ENTRIES];
  logic      le     [MAX_ENTRIES+1];
  logic      lt     [MAX_ENTRIES+1];
  logic      hit_le [MAX_ENTRIES];
  logic      hit_lt [MAX_ENTRIES];
  logic      valid  [MAX_ENTRIES];

  logic [KEY_W-1:0] cmp_x;

  // A lookup compares against its key; an assign compares against the range end.
  assign cmp_x = (req_r.req_type == REQ_ASSIGN) ? req_r.range_end : req_r.lookup_key;
  assign le[MAX_ENTRIES] = 1'b0;
  assign lt[MAX_ENTRIES] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = ent[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ent[i+1];
    end
    assign valid[i] = CW'(i) < cnt_r;

    irm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[i]),
      .left_ent  (left_e),
      .right_ent (right_e),
      .cmp_b     (req_r.range_begin),
      .cmp_x     (cmp_x),
      .valid     (valid[i]),
      .le_next   (le[i+1]),
      .lt_next   (lt[i+1]),
      .ent       (ent[i]),
      .le        (le[i]),
      .lt        (lt[i]),
      .hit_le    (hit_le[i]),
      .hit_lt    (hit_lt[i])
    );
  end

  // Results of the parallel compare, gathered from the one-hot run ends.
  logic [CW-1:0]    p_c, q_c, t_c, ncnt_c;
  logic [VAL_W-1:0] endv_c, prev_c;
  logic             kb_c, ke_c;

  always_comb begin
    p_c    = '0;
    q_c    = '0;
    endv_c = '0;
    prev_c = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_le[i]) begin
        q_c    = q_c | CW'(i + 1);
        endv_c = endv_c | ent[i].val;
      end
      if (hit_lt[i]) begin
        p_c    = p_c | CW'(i + 1);
        prev_c = prev_c | ent[i].val;
      end
    end
    // The new begin breakpoint merges into the entry below it when values match.
    // The end breakpoint merges into the begin one in the same way. Entries above
    // the range never merge, because the old table was already canonical.
    kb_c   = (p_c == '0) || (prev_c != req_r.new_value);
    ke_c   = endv_c != req_r.new_value;
    t_c    = p_c + CW'(kb_c) + CW'(ke_c);
    ncnt_c = t_c + cnt_r - q_c;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cnt_nxt    = cnt_r;
    p_nxt      = p_r;
    s_nxt      = s_r;
    t_nxt      = t_r;
    ncnt_nxt   = ncnt_r;
    kb_nxt     = kb_r;
    ke_nxt     = ke_r;
    endv_nxt   = endv_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctl[i] = '{op: OP_HOLD, data: '0};
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          // A new background value clears the table to one breakpoint.
          cnt_nxt = CW'(1);
          ctl[0]  = '{op: OP_WRITE, data: '{key: '0, val: cfg_wdata}};
        end
        // A request taken in the same cycle works on the cleared table.
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (req_r.req_type == REQ_LOOKUP) begin
          strobe_nxt = 1'b1;
          res_nxt    = '{read_value: endv_c, status: ST_DONE};
          state_nxt  = S_IDLE;
        end else if (!(req_r.range_begin < req_r.range_end)) begin
          strobe_nxt = 1'b1;
          res_nxt    = '{read_value: '0, status: ST_EMPTY};
          state_nxt  = S_IDLE;
        end else if (ncnt_c > CW'(MAX_ENTRIES)) begin
          strobe_nxt = 1'b1;
          res_nxt    = '{read_value: '0, status: ST_FULL};
          state_nxt  = S_IDLE;
        end else begin
          p_nxt     = p_c;
          s_nxt     = q_c;
          t_nxt     = t_c;
          ncnt_nxt  = ncnt_c;
          kb_nxt    = kb_c;
          ke_nxt    = ke_c;
          endv_nxt  = endv_c;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (s_r == t_r) begin
          // The upper part sits in place; drop in the begin and end breakpoints.
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (kb_r && (CW'(i) == p_r)) begin
              ctl[i] = '{op: OP_WRITE,
                         data: '{key: req_r.range_begin, val: req_r.new_value}};
            end else if (ke_r && (CW'(i) == p_r + CW'(kb_r))) begin
              ctl[i] = '{op: OP_WRITE, data: '{key: req_r.range_end, val: endv_r}};
            end
          end
          cnt_nxt    = ncnt_r;
          strobe_nxt = 1'b1;
          res_nxt    = '{read_value: '0, status: ST_DONE};
          state_nxt  = S_IDLE;
        end else if (s_r > t_r) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CW'(i) + CW'(1) >= s_r) begin
              ctl[i].op = OP_SHL;
            end
          end
          s_nxt = s_r - CW'(1);
        end else begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CW'(i) >= s_r + CW'(1)) begin
              ctl[i].op = OP_SHR;
            end
          end
          s_nxt = s_r + CW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= CW'(1);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    p_r    <= p_nxt;
    s_r    <= s_nxt;
    t_r    <= t_nxt;
    ncnt_r <= ncnt_nxt;
    kb_r   <= kb_nxt;
    ke_r   <= ke_nxt;
    endv_r <= endv_nxt;
    res_r  <= res_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire

// ===== rtl/irm_chk.sv =====
`default_nettype none
`include "interval_range_map_unit_assert.svh"
module irm_chk import irm_pkg::*; (
  input wire  clk,
  input wire  rst_n,
  input wire  start,
  input wire  busy,
  input wire  out_strobe,
  input out_t out_res
);

  `IRM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `IRM_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `IRM_ASSERT_IMPLY(a_done_strobe, clk, rst_n, $fell(busy), out_strobe)
  `IRM_ASSERT_IMPLY(a_status_code, clk, rst_n, out_strobe, out_res.status == ST_DONE || out_res.status == ST_EMPTY || out_res.status == ST_FULL)
  `IRM_ASSERT_IMPLY(a_reject_zero, clk, rst_n, out_strobe && out_res.status != ST_DONE, out_res.read_value == '0)

endmodule

bind interval_range_map_unit irm_chk u_irm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
`default_nettype wire
